// ----- hdl/mtr_pkg.sv -----
// ----------------------------------------------------------------------------
// mtr_pkg
// shared constants and helpers for the ranged mt19937 random unit
// ----------------------------------------------------------------------------
`default_nettype none
package mtr_pkg;
  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned POS_W        = 10;

  localparam logic [31:0] TW_MATRIX  = 32'h9908b0df;
  localparam logic [31:0] TW_UPPER   = 32'h80000000;
  localparam logic [31:0] TW_LOWER   = 32'h7fffffff;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc60000;
  localparam logic [31:0] INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] MIX1_MULT  = 32'd1664525;
  localparam logic [31:0] MIX2_MULT  = 32'd1566083941;
  localparam logic [31:0] INIT_SEED  = 32'd19650218;

  localparam logic OP_RANGE = 1'b0;
  localparam logic OP_BITS  = 1'b1;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [31:0] fold30(input logic [31:0] p);
    return p ^ (p >> 30);
  endfunction
endpackage
`default_nettype wire

// ----- hdl/mt19937_ranged_random_unit.sv -----
// ----------------------------------------------------------------------------
// mt19937_ranged_random_unit
// mt19937 source giving ranged integers or top bits of tempered words
// ----------------------------------------------------------------------------
// One request at a time. After reset or a seed write the unit seeds its
// 624-word state ram and takes no request until done. The plain init
// writes each word and forms the next in the multiply state, the two
// mixing sweeps read and then write each word, and the wraps copy the
// last word into word 0. Each word drawn is read, then tempered. Every
// 624th draw first regenerates the ram: three reads and one write per
// word, as the ram has a single read port. A request that draws one word
// goes from idle through the draw, temper and output states, where the
// registered result is flagged valid. Each rejected range draw returns to
// the draw state for another word. Zero-bit and full-span range requests
// need no draw. A result waiting on the output holds off new requests.
`default_nettype none
module mt19937_ranged_random_unit #(
  parameter int unsigned STATE_WORDS  = mtr_pkg::STATE_WORDS,
  parameter int unsigned TWIST_OFFSET = mtr_pkg::TWIST_OFFSET
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        seed_we,
  input  wire logic [31:0] seed_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // bound_a[31:0], bound_b[63:32], bit_count[69:64], pad
  input  wire logic        s_tuser,   // opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // value
);
  localparam int unsigned AW = $clog2(STATE_WORDS + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_INIT  = 4'd1;   // plain init write sweep
  localparam logic [3:0] ST_MRD   = 4'd2;   // mix: read word i
  localparam logic [3:0] ST_MWR   = 4'd3;   // mix: write word i
  localparam logic [3:0] ST_FIX   = 4'd4;   // copy last to word 0
  localparam logic [3:0] ST_TOP   = 4'd5;   // final word 0 write
  localparam logic [3:0] ST_DRAW  = 4'd6;   // issue read / start regen
  localparam logic [3:0] ST_TEMP  = 4'd7;   // temper and decide
  localparam logic [3:0] ST_GR0   = 4'd8;   // regen reads
  localparam logic [3:0] ST_GR1   = 4'd9;
  localparam logic [3:0] ST_GR2   = 4'd10;
  localparam logic [3:0] ST_GWR   = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;
  localparam logic [3:0] ST_MUL   = 4'd13;  // init multiply stage

  logic [31:0] ram [STATE_WORDS];
  logic [31:0] rdata;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata;

  always_ff @(posedge clk) begin
    if (we) ram[waddr] <= wdata;
    rdata <= ram[raddr];
  end

  logic [3:0]  state;
  logic [31:0] seed;
  logic [AW-1:0] idx;
  logic        pass2;
  logic [AW-1:0] cnt;
  logic [31:0] prev, cur, prod, w0, w1;
  logic [AW-1:0] pos;
  logic        op;
  logic [31:0] lo, width;
  logic [5:0]  k;

  logic [AW-1:0] idx_p1, idx_off;
  logic signed [31:0] sa, sb;
  logic [31:0] a_lo, a_hi, a_w;
  logic [5:0]  a_k;
  logic [31:0] y, got, x, v;
  logic [31:0] mix_val;

  always_comb begin
    idx_p1  = (idx == AW'(STATE_WORDS - 1)) ? '0 : idx + 1'b1;
    idx_off = (idx >= AW'(STATE_WORDS - TWIST_OFFSET)) ?
              idx - AW'(STATE_WORDS - TWIST_OFFSET) : idx + AW'(TWIST_OFFSET);
    sa = s_tdata[31:0];
    sb = s_tdata[63:32];
    a_lo = (sa <= sb) ? s_tdata[31:0] : s_tdata[63:32];
    a_hi = (sa <= sb) ? s_tdata[63:32] : s_tdata[31:0];
    a_w  = a_hi - a_lo + 32'd1;
    a_k  = '0;
    for (int b = 0; b < 32; b++) if (a_w[b]) a_k = 6'(b + 1);
    y = mtr_pkg::temper(rdata);
    if (k == 6'd0)       got = '0;
    else if (k >= 6'd32) got = y;
    else                 got = y >> (6'd32 - k);
    x = (w0 & mtr_pkg::TW_UPPER) | (w1 & mtr_pkg::TW_LOWER);
    v = rdata ^ (x >> 1) ^ (x[0] ? mtr_pkg::TW_MATRIX : 32'd0);
    mix_val = pass2 ? ((rdata ^ prod) - 32'(idx)) : ((rdata ^ prod) + seed);
  end

  assign s_tready = (state == ST_IDLE) && !m_tvalid && !seed_we;

  always_comb begin
    we = 1'b0; waddr = idx; raddr = idx; wdata = cur;
    unique case (state)
      ST_INIT: begin we = 1'b1; wdata = cur; end
      ST_MRD:  raddr = idx;
      ST_MWR:  begin we = 1'b1; wdata = mix_val; end
      ST_FIX:  begin we = 1'b1; waddr = '0; wdata = prev; end
      ST_TOP:  begin we = 1'b1; waddr = '0; wdata = mtr_pkg::TW_UPPER; end
      ST_DRAW: raddr = pos;
      ST_GR0:  raddr = idx;
      ST_GR1:  raddr = idx_p1;
      ST_GR2:  raddr = idx_off;
      ST_GWR:  begin we = 1'b1; wdata = v; end
      ST_MUL, ST_TEMP, ST_OUT, ST_IDLE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT; seed <= '0; idx <= '0; cur <= mtr_pkg::INIT_SEED;
      m_tvalid <= 1'b0; pos <= AW'(STATE_WORDS); pass2 <= 1'b0;
    end else if (seed_we) begin
      state <= ST_INIT; seed <= seed_wdata; idx <= '0; cur <= mtr_pkg::INIT_SEED;
      m_tvalid <= 1'b0; pos <= AW'(STATE_WORDS); pass2 <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_INIT: begin
          if (idx == AW'(STATE_WORDS - 1)) begin
            // mixing starts at word 1, chained from word 0
            idx <= AW'(1); cnt <= AW'(STATE_WORDS); prev <= mtr_pkg::INIT_SEED;
            state <= ST_MRD;
          end else begin
            prod <= mtr_pkg::INIT_MULT * mtr_pkg::fold30(cur);
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          cur <= prod + 32'(idx + 1'b1); idx <= idx + 1'b1; state <= ST_INIT;
        end
        ST_MRD: begin
          prod <= (pass2 ? mtr_pkg::MIX2_MULT : mtr_pkg::MIX1_MULT)
                  * mtr_pkg::fold30(prev);
          state <= ST_MWR;
        end
        ST_MWR: begin
          prev <= mix_val;
          if (idx == AW'(STATE_WORDS - 1)) begin
            // wrap: word 0 takes a copy of the last word
            idx <= AW'(1); cnt <= cnt - 1'b1; state <= ST_FIX;
          end else begin
            idx <= idx + 1'b1;
            if (cnt == AW'(1)) begin
              if (pass2) state <= ST_TOP;
              else begin
                pass2 <= 1'b1; cnt <= AW'(STATE_WORDS - 1); state <= ST_MRD;
              end
            end else begin
              cnt <= cnt - 1'b1; state <= ST_MRD;
            end
          end
        end
        ST_FIX: state <= ST_MRD;
        ST_TOP: state <= ST_IDLE;
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            op <= s_tuser;
            if (s_tuser == mtr_pkg::OP_RANGE) begin
              lo <= a_lo; width <= a_w; k <= a_k;
              if (a_w == 32'd0) begin m_tdata <= a_lo; m_tvalid <= 1'b1; end
              else state <= ST_DRAW;
            end else begin
              lo <= '0; width <= '0; k <= s_tdata[69:64];
              if (s_tdata[69:64] == 6'd0) begin m_tdata <= '0; m_tvalid <= 1'b1; end
              else state <= ST_DRAW;
            end
          end
        end
        ST_DRAW: begin
          if (pos >= AW'(STATE_WORDS)) begin idx <= '0; state <= ST_GR0; end
          else begin pos <= pos + 1'b1; state <= ST_TEMP; end
        end
        ST_TEMP: begin
          if (op == mtr_pkg::OP_RANGE && got >= width) state <= ST_DRAW;
          else begin m_tdata <= lo + got; state <= ST_OUT; end
        end
        ST_OUT: begin m_tvalid <= 1'b1; state <= ST_IDLE; end
        ST_GR0: state <= ST_GR1;
        ST_GR1: begin w0 <= rdata; state <= ST_GR2; end
        ST_GR2: begin w1 <= rdata; state <= ST_GWR; end
        ST_GWR: begin
          if (idx == AW'(STATE_WORDS - 1)) begin pos <= '0; state <= ST_DRAW; end
          else begin idx <= idx + 1'b1; state <= ST_GR0; end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> state == ST_IDLE) else $error("request while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst || seed_we)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= AW'(STATE_WORDS)) else $error("read position overflow");
`endif
endmodule
`default_nettype wire

// ----- dv/tb_mt19937_ranged_random_unit.sv -----
// ----------------------------------------------------------------------------
// tb_mt19937_ranged_random_unit
// self-checking bench for the ranged mt19937 unit: a directed table of
// requests, then random range and top-bit requests under several seeds, each
// result compared with a local twister that tracks state and seed
// ----------------------------------------------------------------------------
module tb_mt19937_ranged_random_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 40000;
  localparam int SETTLE_CYCLES   = 3000;
  localparam int RANDOM_REQS     = 1500;

  typedef struct packed {
    logic        opcode;
    logic [31:0] bound_a;
    logic [31:0] bound_b;
    logic [5:0]  bit_count;
    logic        known;     // expected value typed into the table
    logic [31:0] value;
  } req_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        seed_we = 1'b0;
  logic [31:0] seed_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  logic [31:0] twist_mem [mtr_pkg::STATE_WORDS];
  int unsigned twist_pos;
  logic [31:0] expected_values [$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          results_seen = 0;
  int          range_reqs = 0;
  int          bits_reqs = 0;
  bit          idling_on = 1'b1;
  bit          stim_done = 1'b0;
  req_row_t    directed [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mt19937_ranged_random_unit DUT (
    .clk(clk), .rst(rst), .seed_we(seed_we), .seed_wdata(seed_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  function automatic logic [31:0] mix_fold(input logic [31:0] p);
    return p ^ (p >> 30);
  endfunction

  task automatic reseed_twister(input logic [31:0] key);
    int unsigned i;
    twist_mem[0] = mtr_pkg::INIT_SEED;
    for (int k = 1; k < mtr_pkg::STATE_WORDS; k++)
      twist_mem[k] = mtr_pkg::INIT_MULT * mix_fold(twist_mem[k-1]) + k;
    i = 1;
    for (int n = 0; n < mtr_pkg::STATE_WORDS; n++) begin
      twist_mem[i] = (twist_mem[i] ^ (mix_fold(twist_mem[i-1]) * mtr_pkg::MIX1_MULT)) + key;
      i++;
      if (i >= mtr_pkg::STATE_WORDS) begin
        twist_mem[0] = twist_mem[mtr_pkg::STATE_WORDS-1];
        i = 1;
      end
    end
    for (int n = 0; n < mtr_pkg::STATE_WORDS - 1; n++) begin
      twist_mem[i] = (twist_mem[i] ^ (mix_fold(twist_mem[i-1]) * mtr_pkg::MIX2_MULT)) - i;
      i++;
      if (i >= mtr_pkg::STATE_WORDS) begin
        twist_mem[0] = twist_mem[mtr_pkg::STATE_WORDS-1];
        i = 1;
      end
    end
    twist_mem[0] = mtr_pkg::TW_UPPER;
    twist_pos = mtr_pkg::STATE_WORDS;
  endtask

  function automatic logic [31:0] draw_tempered();
    logic [31:0] x, v, y;
    if (twist_pos >= mtr_pkg::STATE_WORDS) begin
      for (int i = 0; i < mtr_pkg::STATE_WORDS; i++) begin
        x = (twist_mem[i] & mtr_pkg::TW_UPPER) |
            (twist_mem[(i+1) % mtr_pkg::STATE_WORDS] & mtr_pkg::TW_LOWER);
        v = twist_mem[(i + mtr_pkg::TWIST_OFFSET) % mtr_pkg::STATE_WORDS] ^ (x >> 1);
        if (x[0]) v = v ^ mtr_pkg::TW_MATRIX;
        twist_mem[i] = v;
      end
      twist_pos = 0;
    end
    y = twist_mem[twist_pos];
    twist_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtr_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtr_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [31:0] top_word_bits(input int unsigned k);
    if (k == 0) return 32'd0;
    if (k >= 32) return draw_tempered();
    return draw_tempered() >> (32 - k);
  endfunction

  function automatic logic [31:0] predict_value(input logic opcode, input logic [31:0] a,
                                                input logic [31:0] b, input logic [5:0] bc);
    logic [31:0] lo, hi, span, got, t;
    int unsigned k;
    if (opcode == mtr_pkg::OP_BITS) return top_word_bits(bc);
    if ($signed(a) <= $signed(b)) begin
      lo = a; hi = b;
    end else begin
      lo = b; hi = a;
    end
    span = hi - lo + 32'd1;
    if (span == 0) return lo;
    k = 0;
    t = span;
    while (t != 0) begin
      k++;
      t = t >> 1;
    end
    do got = top_word_bits(k); while (got >= span);
    return lo + got;
  endfunction

  task automatic send_request(input req_row_t row);
    logic [31:0] want;
    want = predict_value(row.opcode, row.bound_a, row.bound_b, row.bit_count);
    if (row.known && want !== row.value) begin
      $error("table entry disagrees with model: value expected %h, model %h", row.value, want);
      fail_count++;
    end
    if (row.known) want = row.value;
    while (idling_on && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= row.opcode;
    s_tdata  <= {2'b00, row.bit_count, row.bound_b, row.bound_a};
    expected_values.push_back(want);
    if (row.opcode == mtr_pkg::OP_RANGE) range_reqs++;
    else bits_reqs++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] key);
    drain_results();
    seed_we    <= 1'b1;
    seed_wdata <= key;
    @(posedge clk);
    seed_we <= 1'b0;
    reseed_twister(key);
  endtask

  function automatic req_row_t random_request();
    req_row_t r;
    r.known     = 1'b0;
    r.value     = '0;
    r.opcode    = 1'($urandom_range(1));
    r.bound_a   = $urandom;
    r.bound_b   = $urandom;
    r.bit_count = 6'($urandom_range(63));
    case ($urandom_range(5))
      0: r.bound_b = r.bound_a + $urandom_range(40);
      1: r.bound_b = r.bound_a - $urandom_range(1000);
      2: r.bit_count = 6'($urandom_range(32));
      default: ;
    endcase
    return r;
  endfunction

  // result side: random stall, compare with oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (expected_values.size() == 0) begin
          $error("unexpected result value %h", m_tdata);
          fail_count++;
        end else begin
          if (m_tdata !== expected_values[0]) begin
            $error("field value: expected %h, actual %h", expected_values[0], m_tdata);
            fail_count++;
          end
          void'(expected_values.pop_front());
        end
      end
      m_tready <= !(idling_on && $urandom_range(99) < 22);
    end
  end

  // watchdog on cycles without any accepted transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog expired with %0d results pending", expected_values.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int wait_cycles;
    // opcode, bound_a, bound_b, bit_count, known, value
    directed = '{
      '{mtr_pkg::OP_BITS,  32'h0, 32'h0, 6'd0,  1'b1, 32'h0},
      '{mtr_pkg::OP_BITS,  32'h0, 32'h0, 6'd32, 1'b0, 32'h0},
      '{mtr_pkg::OP_BITS,  32'h0, 32'h0, 6'd63, 1'b0, 32'h0},
      '{mtr_pkg::OP_BITS,  32'h0, 32'h0, 6'd1,  1'b0, 32'h0},
      '{mtr_pkg::OP_BITS,  32'h0, 32'h0, 6'd31, 1'b0, 32'h0},
      '{mtr_pkg::OP_BITS,  32'hffffffff, 32'hffffffff, 6'd42, 1'b0, 32'h0},
      '{mtr_pkg::OP_RANGE, 32'h80000000, 32'h7fffffff, 6'd0,  1'b1, 32'h80000000},
      '{mtr_pkg::OP_RANGE, 32'h7fffffff, 32'h80000000, 6'd0,  1'b1, 32'h80000000},
      '{mtr_pkg::OP_RANGE, 32'h00000005, 32'h00000005, 6'd0,  1'b1, 32'h00000005},
      '{mtr_pkg::OP_RANGE, 32'h80000000, 32'h80000000, 6'd0,  1'b1, 32'h80000000},
      '{mtr_pkg::OP_RANGE, 32'h7fffffff, 32'h7fffffff, 6'd63, 1'b1, 32'h7fffffff},
      '{mtr_pkg::OP_RANGE, 32'h00000000, 32'h00000001, 6'd0,  1'b0, 32'h0},
      '{mtr_pkg::OP_RANGE, 32'h0000000a, 32'hfffffff6, 6'd0,  1'b0, 32'h0},
      '{mtr_pkg::OP_RANGE, 32'h80000000, 32'h7ffffffe, 6'd0,  1'b0, 32'h0},
      '{mtr_pkg::OP_RANGE, 32'h80000001, 32'h7fffffff, 6'd0,  1'b0, 32'h0},
      '{mtr_pkg::OP_RANGE, 32'h00000000, 32'h40000000, 6'd0,  1'b0, 32'h0},
      '{mtr_pkg::OP_RANGE, 32'hffffffff, 32'h00000000, 6'd0,  1'b0, 32'h0},
      '{mtr_pkg::OP_RANGE, 32'h00000000, 32'h00000002, 6'd0,  1'b0, 32'h0}
    };
    reseed_twister(32'd0);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_request(directed[i]);

    // phases under different seeds, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_seed(32'hffffffff);
        1: write_seed(32'h00000000);
        2: write_seed(32'd5489);
        default: write_seed($urandom);
      endcase
      idling_on = (ph != 2);
      for (int n = 0; n < RANDOM_REQS / 5; n++) begin
        send_request(random_request());
        if (n == 100 && ph == 1) drain_results();
      end
    end
    drain_results();
    stim_done = 1'b1;
    wait_cycles = 0;
    while (wait_cycles < SETTLE_CYCLES) begin
      @(posedge clk);
      wait_cycles++;
    end
    $display("covered %0d range and %0d top-bit requests over 6 seeds, %0d results checked",
             range_reqs, bits_reqs, results_seen);
    if (fail_count == 0 && expected_values.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
